FILE: hdl/i2ctfb_pkg.sv
// ----------------------------------------------------------------------------
// i2ctfb_pkg
// Shared types and constants of the bus-target FIFO bridge: event codes,
// command bytes, field widths and the default FIFO depth.
// ----------------------------------------------------------------------------
package i2ctfb_pkg;

    // Field widths of one input item and one result item
    localparam int FUNC_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 10;

    typedef logic [FUNC_W-1:0]  t_func;
    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [COUNT_W-1:0] t_count;

    // Event codes
    localparam t_func FUNC_WR_ADDR   = 3'd0;
    localparam t_func FUNC_WR_DATA   = 3'd1;
    localparam t_func FUNC_RD_ADDR   = 3'd2;
    localparam t_func FUNC_RD_DATA   = 3'd3;
    localparam t_func FUNC_HOST_PUSH = 3'd4;
    localparam t_func FUNC_HOST_POP  = 3'd5;

    // Command bytes
    localparam t_byte CMD_FILL_COUNT = 8'hFD;
    localparam t_byte CMD_STREAM     = 8'hFF;

    // Saturation limit of the burst counter
    localparam t_count BURST_MAX = 10'd1023;

    // Default number of slots per FIFO (one slot always stays free)
    localparam int DEF_FIFO_DEPTH = 64;

endpackage

FILE: hdl/i2ctfb_if.sv
// ----------------------------------------------------------------------------
// i2ctfb_if
// Valid/ready channels of the bridge: event items in, result items out.
// ----------------------------------------------------------------------------
interface i2ctfb_in_if
    import i2ctfb_pkg::*;
;
    logic  valid;
    logic  ready;
    t_func func;
    t_byte data;
    logic  burst_last;

    modport source (output valid, output func, output data, output burst_last,
                    input ready);
    modport sink   (input valid, input func, input data, input burst_last,
                    output ready);
endinterface

interface i2ctfb_out_if
    import i2ctfb_pkg::*;
;
    logic   valid;
    logic   ready;
    t_byte  read_data;
    logic   got_byte;
    logic   dropped;
    t_count burst_count;

    modport source (output valid, output read_data, output got_byte,
                    output dropped, output burst_count, input ready);
    modport sink   (input valid, input read_data, input got_byte,
                    input dropped, input burst_count, output ready);
endinterface

FILE: hdl/i2c_target_fifo_bridge.sv
// ----------------------------------------------------------------------------
// i2c_target_fifo_bridge
// Bridges bus-target events and a host through a transmit and a receive
// byte ring FIFO that overwrite their oldest byte when full.
// ----------------------------------------------------------------------------
//
//   Channel    Dir   Port       Payload
//   ---------  ----  ---------  ------------------------------------------
//   events     in    i_item     func, data, burst_last
//   results    out   o_result   read_data, got_byte, dropped, burst_count
//
// One item per cycle while results are taken; its result shows in the cycle
// after it is accepted, in step with the synchronous read port of each FIFO memory.
// An item is accepted while the result register is empty or being taken.
// A stalled result holds; no item is accepted until it is taken.
// Reset clears pointers, command and burst state; FIFO memories are not
// cleared, since no slot is read before it is written.
//
module i2c_target_fifo_bridge
    import i2ctfb_pkg::*;
#(
    parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    i2ctfb_in_if.sink    i_item,
    i2ctfb_out_if.source o_result
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(FIFO_DEPTH);

    // Source of the result byte
    localparam logic [1:0] SRC_REG = 2'd0;
    localparam logic [1:0] SRC_TX  = 2'd1;
    localparam logic [1:0] SRC_RX  = 2'd2;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    // FIFO memories and their read data registers
    t_byte r_tx_mem [FIFO_DEPTH];
    t_byte r_rx_mem [FIFO_DEPTH];
    t_byte r_tx_q;
    t_byte r_rx_q;

    // Control state
    logic [PTR_W-1:0] r_tx_rd_ptr, n_tx_rd_ptr;
    logic [PTR_W-1:0] r_tx_wr_ptr, n_tx_wr_ptr;
    logic [PTR_W-1:0] r_rx_rd_ptr, n_rx_rd_ptr;
    logic [PTR_W-1:0] r_rx_wr_ptr, n_rx_wr_ptr;
    t_byte            r_cmd, n_cmd;
    logic             r_expect_cmd, n_expect_cmd;
    t_count           r_burst, n_burst;

    // Result register
    logic       r_out_valid;
    logic [1:0] r_src, n_src;
    t_byte      r_rdata, n_rdata;
    logic       r_got, n_got;
    logic       r_drop, n_drop;
    t_count     r_bcount, n_bcount;

    // Memory port controls
    logic tx_we, rx_we, tx_re, rx_re;

    logic           accept;
    logic           tx_empty, rx_empty;
    logic           tx_full, rx_full;
    logic [PTR_W:0] tx_fill;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;

    assign tx_empty = (r_tx_rd_ptr == r_tx_wr_ptr);
    assign rx_empty = (r_rx_rd_ptr == r_rx_wr_ptr);
    assign tx_full  = (next_slot(r_tx_wr_ptr) == r_tx_rd_ptr);
    assign rx_full  = (next_slot(r_rx_wr_ptr) == r_rx_rd_ptr);

    // Transmit fill count, wrapping at the depth
    always_comb begin
        tx_fill = {1'b0, r_tx_wr_ptr} - {1'b0, r_tx_rd_ptr};
        if (r_tx_wr_ptr < r_tx_rd_ptr) begin
            tx_fill = tx_fill + DEPTH_EXT;
        end
    end

    // Decode one event: pointer moves, memory accesses and result fields
    always_comb begin
        n_tx_rd_ptr  = r_tx_rd_ptr;
        n_tx_wr_ptr  = r_tx_wr_ptr;
        n_rx_rd_ptr  = r_rx_rd_ptr;
        n_rx_wr_ptr  = r_rx_wr_ptr;
        n_cmd        = r_cmd;
        n_expect_cmd = r_expect_cmd;
        n_burst      = r_burst;
        n_src        = SRC_REG;
        n_rdata      = '0;
        n_got        = 1'b0;
        n_drop       = 1'b0;
        n_bcount     = '0;
        tx_we        = 1'b0;
        rx_we        = 1'b0;
        tx_re        = 1'b0;
        rx_re        = 1'b0;

        if (accept) begin
            case (i_item.func)
                FUNC_WR_ADDR: begin
                    n_expect_cmd = 1'b1;
                end
                FUNC_WR_DATA: begin
                    if (r_expect_cmd) begin
                        n_expect_cmd = 1'b0;
                        n_cmd        = i_item.data;
                    end else begin
                        rx_we       = 1'b1;
                        n_rx_wr_ptr = next_slot(r_rx_wr_ptr);
                        if (rx_full) begin
                            n_rx_rd_ptr = next_slot(r_rx_rd_ptr);
                            n_drop      = 1'b1;
                        end
                    end
                end
                FUNC_RD_ADDR: begin
                    if (r_cmd == CMD_FILL_COUNT) begin
                        n_rdata = BYTE_W'(tx_fill);
                    end else if (!tx_empty) begin
                        tx_re       = 1'b1;
                        n_src       = SRC_TX;
                        n_got       = 1'b1;
                        n_tx_rd_ptr = next_slot(r_tx_rd_ptr);
                    end
                end
                FUNC_RD_DATA: begin
                    if (r_cmd == CMD_STREAM && !tx_empty) begin
                        tx_re       = 1'b1;
                        n_src       = SRC_TX;
                        n_got       = 1'b1;
                        n_tx_rd_ptr = next_slot(r_tx_rd_ptr);
                    end
                end
                FUNC_HOST_PUSH: begin
                    tx_we       = 1'b1;
                    n_tx_wr_ptr = next_slot(r_tx_wr_ptr);
                    if (tx_full) begin
                        n_tx_rd_ptr = next_slot(r_tx_rd_ptr);
                        n_drop      = 1'b1;
                    end
                    n_bcount = (r_burst != BURST_MAX) ? r_burst + 1'b1 : r_burst;
                    n_burst  = i_item.burst_last ? '0 : n_bcount;
                end
                FUNC_HOST_POP: begin
                    n_bcount = r_burst;
                    if (!rx_empty) begin
                        rx_re       = 1'b1;
                        n_src       = SRC_RX;
                        n_got       = 1'b1;
                        n_rx_rd_ptr = next_slot(r_rx_rd_ptr);
                        if (r_burst != BURST_MAX) begin
                            n_bcount = r_burst + 1'b1;
                        end
                    end
                    n_burst = i_item.burst_last ? '0 : n_bcount;
                end
                default: begin
                end
            endcase
        end
    end

    // Transmit memory: host writes, bus reads
    always_ff @(posedge i_clk) begin
        if (tx_we) begin
            r_tx_mem[r_tx_wr_ptr] <= i_item.data;
        end
        if (tx_re) begin
            r_tx_q <= r_tx_mem[r_tx_rd_ptr];
        end
    end

    // Receive memory: bus writes, host reads
    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            r_rx_mem[r_rx_wr_ptr] <= i_item.data;
        end
        if (rx_re) begin
            r_rx_q <= r_rx_mem[r_rx_rd_ptr];
        end
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_rd_ptr  <= '0;
            r_tx_wr_ptr  <= '0;
            r_rx_rd_ptr  <= '0;
            r_rx_wr_ptr  <= '0;
            r_cmd        <= '0;
            r_expect_cmd <= 1'b0;
            r_burst      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_tx_rd_ptr  <= n_tx_rd_ptr;
            r_tx_wr_ptr  <= n_tx_wr_ptr;
            r_rx_rd_ptr  <= n_rx_rd_ptr;
            r_rx_wr_ptr  <= n_rx_wr_ptr;
            r_cmd        <= n_cmd;
            r_expect_cmd <= n_expect_cmd;
            r_burst      <= n_burst;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load result fields with each accepted item, hold otherwise
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_src    <= n_src;
            r_rdata  <= n_rdata;
            r_got    <= n_got;
            r_drop   <= n_drop;
            r_bcount <= n_bcount;
        end
    end

    // Drive the result channel
    assign o_result.valid       = r_out_valid;
    assign o_result.read_data   = (r_src == SRC_TX) ? r_tx_q :
                                  (r_src == SRC_RX) ? r_rx_q : r_rdata;
    assign o_result.got_byte    = r_got;
    assign o_result.dropped     = r_drop;
    assign o_result.burst_count = r_bcount;

    // A pop and a push never come from the same item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !(o_result.got_byte && o_result.dropped))
        else $error("got_byte and dropped both set");

    // A memory byte is shown exactly when a pop yielded one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.got_byte == (r_src != SRC_REG)))
        else $error("result source disagrees with got_byte");

    // Pointers stay inside the ring
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_rd_ptr <= LAST_SLOT && r_tx_wr_ptr <= LAST_SLOT &&
        r_rx_rd_ptr <= LAST_SLOT && r_rx_wr_ptr <= LAST_SLOT)
        else $error("FIFO pointer beyond depth");

    // An accepted item always leaves a result behind
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted item produced no result");

endmodule

FILE: sim/i2c_target_fifo_bridge_tb.sv
// ----------------------------------------------------------------------------
// i2c_target_fifo_bridge_tb
// Self-checking bench for the bus-target FIFO bridge. A scoreboard class
// mirrors both ring FIFOs, the command capture and the burst counter, and
// predicts one result per accepted event. Stimulus is a short directed
// pass, a long host push burst that drives the counter into saturation,
// then mixed bus and host sequences. Both sides idle at random, and the
// result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import i2ctfb_pkg::*;

typedef enum int {TX_FIFO = 0, RX_FIFO = 1} t_fifo_sel;

typedef struct packed {
    t_byte  read_data;
    logic   got_byte;
    logic   dropped;
    t_count burst_count;
} t_bridge_result;

class bridge_scoreboard;

    // Mirror of the bridge state
    t_byte  fifo_mem [2][DEF_FIFO_DEPTH];
    int     rd_ptr [2];
    int     wr_ptr [2];
    t_byte  command;
    bit     arm_command;
    t_count burst_tally;

    t_bridge_result pending_results [$];

    int mismatches;
    int results_checked;
    int overwrites;
    int bytes_popped;
    int fill_answers;
    int saturated_hits;

    function new();
        rd_ptr = '{0, 0};
        wr_ptr = '{0, 0};
        command = '0;
        arm_command = 1'b0;
        burst_tally = '0;
        mismatches = 0;
        results_checked = 0;
        overwrites = 0;
        bytes_popped = 0;
        fill_answers = 0;
        saturated_hits = 0;
    endfunction

    function int slot_after(int p);
        return (p + 1 >= DEF_FIFO_DEPTH) ? 0 : p + 1;
    endfunction

    // Push with overwrite of the oldest byte; flag the overwrite
    function bit push_byte(t_fifo_sel q, t_byte v);
        bit lost;
        lost = 1'b0;
        if (slot_after(wr_ptr[q]) == rd_ptr[q]) begin
            rd_ptr[q] = slot_after(rd_ptr[q]);
            lost = 1'b1;
            overwrites++;
        end
        fifo_mem[q][wr_ptr[q]] = v;
        wr_ptr[q] = slot_after(wr_ptr[q]);
        return lost;
    endfunction

    // Pop one byte when present, else answer zero
    function bit pop_byte(t_fifo_sel q, output t_byte v);
        if (rd_ptr[q] == wr_ptr[q]) begin
            v = '0;
            return 1'b0;
        end
        v = fifo_mem[q][rd_ptr[q]];
        rd_ptr[q] = slot_after(rd_ptr[q]);
        bytes_popped++;
        return 1'b1;
    endfunction

    // Advance the saturating burst counter; clear it after a burst end
    function t_count tally_burst(bit moved, logic last);
        t_count shown;
        if (moved && burst_tally < BURST_MAX)
            burst_tally++;
        shown = burst_tally;
        if (last)
            burst_tally = '0;
        if (shown == BURST_MAX)
            saturated_hits++;
        return shown;
    endfunction

    // Predict the result of one accepted event and queue it
    function void note_item(t_func f, t_byte d, logic last);
        t_bridge_result r;
        int fill;
        r = '0;
        case (f)
            FUNC_WR_ADDR: begin
                arm_command = 1'b1;
            end
            FUNC_WR_DATA: begin
                if (arm_command) begin
                    arm_command = 1'b0;
                    command = d;
                end else begin
                    r.dropped = push_byte(RX_FIFO, d);
                end
            end
            FUNC_RD_ADDR: begin
                if (command == CMD_FILL_COUNT) begin
                    fill = (wr_ptr[TX_FIFO] >= rd_ptr[TX_FIFO])
                         ? wr_ptr[TX_FIFO] - rd_ptr[TX_FIFO]
                         : DEF_FIFO_DEPTH + wr_ptr[TX_FIFO] - rd_ptr[TX_FIFO];
                    r.read_data = t_byte'(fill);
                    fill_answers++;
                end else begin
                    r.got_byte = pop_byte(TX_FIFO, r.read_data);
                end
            end
            FUNC_RD_DATA: begin
                if (command == CMD_STREAM)
                    r.got_byte = pop_byte(TX_FIFO, r.read_data);
            end
            FUNC_HOST_PUSH: begin
                r.dropped = push_byte(TX_FIFO, d);
                r.burst_count = tally_burst(1'b1, last);
            end
            FUNC_HOST_POP: begin
                r.got_byte = pop_byte(RX_FIFO, r.read_data);
                r.burst_count = tally_burst(r.got_byte, last);
            end
            default: begin
            end
        endcase
        pending_results.push_back(r);
    endfunction

    // Compare one result with the oldest prediction
    function void check_result(t_bridge_result seen);
        t_bridge_result want;
        results_checked++;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] unexpected result: data %02h got %0b drop %0b cnt %0d",
                         $time, seen.read_data, seen.got_byte, seen.dropped,
                         seen.burst_count);
            return;
        end
        want = pending_results.pop_front();
        if (seen.read_data != want.read_data || seen.got_byte != want.got_byte ||
            seen.dropped != want.dropped || seen.burst_count != want.burst_count) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] result %0d: exp %02h/%0b/%0b/%0d act %02h/%0b/%0b/%0d",
                         $time, results_checked, want.read_data, want.got_byte,
                         want.dropped, want.burst_count, seen.read_data,
                         seen.got_byte, seen.dropped, seen.burst_count);
        end
    endfunction

endclass

module i2c_target_fifo_bridge_tb;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 4;
    localparam int SAT_PUSHES     = 1035;
    localparam int MIX_ITEMS      = 80;
    localparam int CALM_ITEMS     = 30;

    // Event codes with no function
    localparam t_func FUNC_SPARE_LO = 3'd6;
    localparam t_func FUNC_SPARE_HI = 3'd7;

    logic i_clk;
    logic i_rst_n;

    i2ctfb_in_if  item_ch ();
    i2ctfb_out_if result_ch ();

    bridge_scoreboard sb = new();

    int items_sent  = 0;
    bit calm        = 1'b0;
    bit hold_armed  = 1'b0;

    i2c_target_fifo_bridge i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_byte any_byte();
        return t_byte'($urandom_range(0, 255));
    endfunction

    function automatic logic any_bit();
        return $urandom_range(0, 1) == 1;
    endfunction

    // Fill-count, stream or arbitrary command byte
    function automatic t_byte pick_command();
        case ($urandom_range(0, 2))
            0:       return CMD_FILL_COUNT;
            1:       return CMD_STREAM;
            default: return any_byte();
        endcase
    endfunction

    // Offer one item, with an optional idle burst first, and hold until taken
    task automatic send_item(t_func f, t_byte d, logic last);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.func       <= f;
        item_ch.data       <= d;
        item_ch.burst_last <= last;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        sb.note_item(f, d, last);
        items_sent++;
    endtask

    // Arm command capture and load a command byte
    task automatic set_command(t_byte cmd);
        send_item(FUNC_WR_ADDR, any_byte(), any_bit());
        send_item(FUNC_WR_DATA, cmd, any_bit());
    endtask

    // Host push or pop burst, ended on its last item
    task automatic host_burst(t_func f, int n);
        for (int i = 0; i < n; i++)
            send_item(f, any_byte(), i == n - 1);
    endtask

    // Result side: check, stall in bursts, and hold off once for a long stretch
    initial begin : result_sink
        int stall_left;
        int hold_left;
        bit hold_done;
        t_bridge_result seen;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_ch.valid && result_ch.ready) begin
                seen.read_data   = result_ch.read_data;
                seen.got_byte    = result_ch.got_byte;
                seen.dropped     = result_ch.dropped;
                seen.burst_count = result_ch.burst_count;
                sb.check_result(seen);
            end
            if (hold_armed && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 4);
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Main sequence
    initial begin : stimulus
        int pushes;
        int mix_start;
        int n;
        t_func f;

        i_rst_n            <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.func       <= FUNC_WR_ADDR;
        item_ch.data       <= '0;
        item_ch.burst_last <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty pops, unused codes, fill count, stream reads
        send_item(FUNC_HOST_POP, 8'h00, 1'b1);
        send_item(FUNC_RD_ADDR, 8'hFF, 1'b0);
        send_item(FUNC_RD_DATA, 8'h00, 1'b1);
        send_item(FUNC_SPARE_LO, 8'hFF, 1'b1);
        send_item(FUNC_SPARE_HI, 8'h00, 1'b0);
        send_item(FUNC_WR_ADDR, 8'hA5, 1'b0);
        send_item(FUNC_WR_DATA, CMD_FILL_COUNT, 1'b0);
        send_item(FUNC_RD_ADDR, 8'h00, 1'b0);
        send_item(FUNC_HOST_PUSH, 8'h00, 1'b0);
        send_item(FUNC_HOST_PUSH, 8'hFF, 1'b0);
        send_item(FUNC_HOST_PUSH, 8'h5A, 1'b1);
        send_item(FUNC_RD_ADDR, 8'h00, 1'b1);
        set_command(CMD_STREAM);
        send_item(FUNC_RD_ADDR, 8'h00, 1'b0);
        send_item(FUNC_RD_DATA, 8'h00, 1'b0);
        send_item(FUNC_RD_DATA, 8'hFF, 1'b1);
        send_item(FUNC_RD_DATA, 8'h00, 1'b0);
        set_command(8'h12);
        send_item(FUNC_RD_DATA, 8'h00, 1'b0);
        send_item(FUNC_WR_DATA, 8'h00, 1'b1);
        send_item(FUNC_WR_DATA, 8'hFF, 1'b0);
        host_burst(FUNC_HOST_POP, 3);

        // One long push burst: overwrite the transmit FIFO, saturate the counter
        pushes = 0;
        while (pushes < SAT_PUSHES) begin
            if ($urandom_range(0, 49) == 0) begin
                f = t_func'($urandom_range(0, 7));
                if (f == FUNC_HOST_PUSH || f == FUNC_HOST_POP)
                    f = FUNC_RD_DATA;
                send_item(f, any_byte(), any_bit());
            end else begin
                send_item(FUNC_HOST_PUSH, any_byte(), 1'b0);
                pushes++;
            end
        end
        send_item(FUNC_HOST_PUSH, any_byte(), 1'b1);

        // Mixed bus and host sequences, with noise and broken sequences
        hold_armed = 1'b1;
        mix_start  = items_sent;
        while (items_sent - mix_start < MIX_ITEMS) begin
            if (items_sent - mix_start >= MIX_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            case ($urandom_range(0, 7))
                0, 1: begin
                    set_command(pick_command());
                    n = $urandom_range(1, 80);
                    repeat (n) send_item(FUNC_WR_DATA, any_byte(), any_bit());
                end
                2, 3: begin
                    set_command(pick_command());
                    send_item(FUNC_RD_ADDR, any_byte(), any_bit());
                    n = $urandom_range(0, 20);
                    repeat (n) send_item(FUNC_RD_DATA, any_byte(), any_bit());
                end
                4: host_burst(FUNC_HOST_PUSH, $urandom_range(1, 70));
                5: host_burst(FUNC_HOST_POP, $urandom_range(1, 70));
                6: begin
                    n = $urandom_range(1, 5);
                    repeat (n) send_item(t_func'($urandom_range(0, 7)), any_byte(), any_bit());
                end
                default: begin
                    // drop the command byte: address followed by a read or a second address
                    send_item(FUNC_WR_ADDR, any_byte(), any_bit());
                    send_item(any_bit() ? FUNC_RD_ADDR : FUNC_WR_ADDR, any_byte(), any_bit());
                end
            endcase
        end
        item_ch.valid <= 1'b0;

        // Drain the results, then let the pipeline settle
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d events and %0d results: %0d overwrites, %0d bytes popped,",
                 items_sent, sb.results_checked, sb.overwrites, sb.bytes_popped);
        $display("%0d fill-count answers, %0d results at burst saturation, %0d mismatches.",
                 sb.fill_answers, sb.saturated_hits, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: i2c_target_fifo_bridge.f
hdl/i2ctfb_pkg.sv
hdl/i2ctfb_if.sv
hdl/i2c_target_fifo_bridge.sv
sim/i2c_target_fifo_bridge_tb.sv
